// ----- src/msv_pkg.sv -----
`timescale 1ns / 1ps
// Package for the mono sine voice: widths, constants, command codes,
// the controller-to-datapath command struct and the quarter-wave sine ROM.
// No dependencies.
package msv_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int PHASE_BITS      = 32;
  localparam int SAMPLE_BITS     = 16;

  localparam int QUARTER_BITS  = SINE_TABLE_BITS - 2;
  localparam int QUARTER_DEPTH = 1 << QUARTER_BITS;
  localparam int X_SHIFT       = 18 - SINE_TABLE_BITS;

  localparam int KEY_W       = 8;
  localparam int RATE_W      = 16;
  localparam int A4_W        = 27;
  localparam int ENV_W       = 16;
  localparam int GAIN_W      = 16;
  localparam int SINE_W      = 17;
  localparam int RATIO_W     = 17;
  localparam int NOTE_PROD_W = A4_W + RATIO_W;
  localparam int OCT_UP_MAX  = 4;
  localparam int STEP_WIDE_W = NOTE_PROD_W + OCT_UP_MAX + PHASE_BITS;
  localparam int SHIFT_W     = 6;
  localparam int OCT_W       = 5;
  localparam int UKEY_W      = KEY_W + 1;
  localparam int OCT_MUL_W   = UKEY_W + 8;
  localparam int ENV_SRC_W   = ENV_W + 1;
  localparam int ENV_PROD_W  = RATE_W + ENV_SRC_W;
  localparam int ENV_DELTA_W = ENV_PROD_W + 1 - 16;
  localparam int MAG_W       = SINE_W + ENV_W;
  localparam int MIX_W       = MAG_W + GAIN_W;
  localparam int OUT_SHIFT   = 48 - SAMPLE_BITS;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;

  // key + 135 is key - 69 offset by 17 octaves; 171/2048 approximates 1/12
  localparam logic [UKEY_W-1:0]    KEY_BIAS   = UKEY_W'(135);
  localparam logic [OCT_MUL_W-1:0] RECIP_12   = OCT_MUL_W'(171);
  localparam int                   RECIP_SH   = 11;
  localparam logic [UKEY_W-1:0]    SEMIS      = UKEY_W'(12);
  localparam logic [SHIFT_W-1:0]   SHIFT_BASE = SHIFT_W'(16 + OCT_UP_MAX + 17);

  localparam logic [ENV_SRC_W-1:0]   ENV_ONE    = ENV_SRC_W'(65536);
  localparam logic [ENV_W-1:0]       ENV_MAX    = ENV_W'(65535);
  localparam logic [ENV_PROD_W:0]    ENV_ROUND  = (ENV_PROD_W + 1)'(65535);
  localparam logic [GAIN_W-1:0]      GAIN_ONE   = GAIN_W'(32768);
  localparam logic [GAIN_W-1:0]      GAIN_RESET = GAIN_W'(26214);
  localparam logic [SINE_W-1:0]      SINE_ONE   = SINE_W'(65536);
  localparam logic [SAMPLE_BITS:0]   SAMPLE_MAX = (SAMPLE_BITS + 1)'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [RATE_W-1:0]      RATE_RESET = RATE_W'(273);
  localparam logic [A4_W-1:0]        A4_RESET   = A4_W'(39370534);
  localparam logic [KEY_W-1:0]       KEY_NONE   = '1;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_NOTE_ON  = 2'd1,
    CMD_NOTE_OFF = 2'd2,
    CMD_SET_GAIN = 2'd3
  } cmd_code_t;

  typedef enum logic {
    REG_ENV_RATE = 1'b0,
    REG_A4_INC   = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic tick_start;
    logic note_start;
    logic note_off;
    logic gain_set;
    logic env_update;
    logic mul1;
    logic mul2;
    logic out_load;
    logic note_mul;
    logic note_shift;
  } dp_cmd_t;

  typedef logic [SINE_W-1:0] sine_rom_t [QUARTER_DEPTH];

  function automatic logic [SINE_W-1:0] quarter_sine(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] t;
    x2 = (x * x) >> 16;
    t  = (64'd4640 * x2) >> 16;
    t  = 64'd42048 - t;
    t  = (t * x2) >> 16;
    t  = 64'd102944 - t;
    t  = (t * x) >> 16;
    return t[SINE_W-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i < QUARTER_DEPTH; i++) begin
      rom[i] = quarter_sine(64'(i) << X_SHIFT);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  function automatic logic [RATIO_W-1:0] semitone_ratio(input logic [3:0] semi);
    logic [RATIO_W-1:0] r;
    case (semi)
      4'd0:    r = RATIO_W'(65536);
      4'd1:    r = RATIO_W'(69433);
      4'd2:    r = RATIO_W'(73562);
      4'd3:    r = RATIO_W'(77936);
      4'd4:    r = RATIO_W'(82570);
      4'd5:    r = RATIO_W'(87480);
      4'd6:    r = RATIO_W'(92682);
      4'd7:    r = RATIO_W'(98193);
      4'd8:    r = RATIO_W'(104032);
      4'd9:    r = RATIO_W'(110218);
      4'd10:   r = RATIO_W'(116772);
      4'd11:   r = RATIO_W'(123715);
      default: r = RATIO_W'(65536);
    endcase
    return r;
  endfunction

endpackage

// ----- src/msv_regs.sv -----
`timescale 1ns / 1ps
// APB-style configuration registers: envelope rate and A4 phase increment.
// Depends on msv_pkg.
module msv_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [msv_pkg::PADDR_W-1:0]       paddr,
  input  logic [msv_pkg::PDATA_W-1:0]       pwdata,
  output logic [msv_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready,
  output logic [msv_pkg::RATE_W-1:0]        env_rate,
  output logic [msv_pkg::A4_W-1:0]          a4_increment
);

  logic                 wr_en;
  msv_pkg::reg_index_t  reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = msv_pkg::reg_index_t'(paddr[msv_pkg::PADDR_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      env_rate     <= msv_pkg::RATE_RESET;
      a4_increment <= msv_pkg::A4_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        msv_pkg::REG_ENV_RATE: env_rate     <= pwdata[msv_pkg::RATE_W-1:0];
        msv_pkg::REG_A4_INC:   a4_increment <= pwdata[msv_pkg::A4_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      msv_pkg::REG_ENV_RATE: prdata = msv_pkg::PDATA_W'(env_rate);
      msv_pkg::REG_A4_INC:   prdata = msv_pkg::PDATA_W'(a4_increment);
      default:               prdata = '0;
    endcase
  end

endmodule

// ----- src/msv_ctrl.sv -----
`timescale 1ns / 1ps
// Sequencer for the sine voice: decodes transfers, steps the datapath
// through tick and note-on work, owns the output valid flag. Depends on msv_pkg.
module msv_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        command,
  output logic              out_valid,
  input  logic              out_ready,
  output msv_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ENV,
    S_MUL1,
    S_MUL2,
    S_OUT,
    S_NOTE_MUL,
    S_NOTE_SHIFT
  } state_t;

  state_t              state;
  logic                in_xfer;
  logic                out_free;
  msv_pkg::cmd_code_t  code;

  assign code     = msv_pkg::cmd_code_t'(command);
  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  always_comb begin
    cmd            = '0;
    cmd.tick_start = in_xfer & (code == msv_pkg::CMD_TICK);
    cmd.note_start = in_xfer & (code == msv_pkg::CMD_NOTE_ON);
    cmd.note_off   = in_xfer & (code == msv_pkg::CMD_NOTE_OFF);
    cmd.gain_set   = in_xfer & (code == msv_pkg::CMD_SET_GAIN);
    cmd.env_update = (state == S_ENV);
    cmd.mul1       = (state == S_MUL1);
    cmd.mul2       = (state == S_MUL2);
    cmd.out_load   = (state == S_OUT) & out_free;
    cmd.note_mul   = (state == S_NOTE_MUL);
    cmd.note_shift = (state == S_NOTE_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd.tick_start) begin
            state <= S_ENV;
          end else if (cmd.note_start) begin
            state <= S_NOTE_MUL;
          end
        end
        S_ENV:        state <= S_MUL1;
        S_MUL1:       state <= S_MUL2;
        S_MUL2:       state <= S_OUT;
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_NOTE_MUL:   state <= S_NOTE_SHIFT;
        S_NOTE_SHIFT: state <= S_IDLE;
        default:      state <= S_IDLE;
      endcase
    end
  end

  a_one_cmd: assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one datapath command at once");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("output register overwritten while a result waits");

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.tick_start |=> !in_ready ##1 !in_ready ##1 !in_ready ##1 !in_ready)
    else $error("input taken while a tick is in progress");

  a_note_seq: assert property (@(posedge clk) disable iff (rst)
    cmd.note_start |=> cmd.note_mul ##1 cmd.note_shift ##1 in_ready)
    else $error("note-on sequence broken");

endmodule

// ----- src/msv_dp.sv -----
`timescale 1ns / 1ps
// Datapath of the sine voice: phase accumulator, envelope, gain, note-on step
// computation and sample formatting. Driven by msv_ctrl. Depends on msv_pkg.
module msv_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  msv_pkg::dp_cmd_t                    cmd,
  input  logic signed [msv_pkg::KEY_W-1:0]    key,
  input  logic [msv_pkg::GAIN_W-1:0]          gain_value,
  input  logic [msv_pkg::RATE_W-1:0]          env_rate,
  input  logic [msv_pkg::A4_W-1:0]            a4_increment,
  output logic signed [msv_pkg::SAMPLE_BITS-1:0] sample
);

  localparam int QB = msv_pkg::QUARTER_BITS;
  localparam int PB = msv_pkg::PHASE_BITS;
  localparam int SB = msv_pkg::SAMPLE_BITS;

  // architectural state
  logic [PB-1:0]                     phase_acc;
  logic [PB-1:0]                     phase_step;
  logic [msv_pkg::ENV_W-1:0]         envelope;
  logic                              gate_open;
  logic [msv_pkg::KEY_W-1:0]         held_key;
  logic [msv_pkg::GAIN_W-1:0]        out_gain;

  // working registers
  logic [msv_pkg::ENV_PROD_W-1:0]    env_prod;
  logic [msv_pkg::SINE_W-1:0]        sine_mag;
  logic [msv_pkg::MAG_W-1:0]         mag_env;
  logic [msv_pkg::MIX_W-1:0]         mix;
  logic [msv_pkg::UKEY_W-1:0]        ukey;
  logic [msv_pkg::OCT_W-1:0]         oct;
  logic [msv_pkg::NOTE_PROD_W-1:0]   note_prod;
  logic [msv_pkg::SHIFT_W-1:0]       step_shr;

  // phase decode
  logic [msv_pkg::SINE_TABLE_BITS-1:0] idx;
  logic [1:0]                          quad;
  logic [QB-1:0]                       j;
  logic [QB:0]                         k;
  logic [msv_pkg::SINE_W-1:0]          rom_word;

  assign idx  = phase_acc[PB-1 -: msv_pkg::SINE_TABLE_BITS];
  assign quad = idx[msv_pkg::SINE_TABLE_BITS-1 -: 2];
  assign j    = idx[QB-1:0];
  assign k    = quad[0] ? ((QB + 1)'(1) << QB) - {1'b0, j} : {1'b0, j};
  assign rom_word = k[QB] ? msv_pkg::SINE_ONE : msv_pkg::SINE_ROM[k[QB-1:0]];

  // envelope step
  logic [msv_pkg::ENV_SRC_W-1:0]   env_src;
  logic [msv_pkg::ENV_PROD_W:0]    env_sum;
  logic [msv_pkg::ENV_DELTA_W-1:0] env_delta;
  logic [msv_pkg::ENV_DELTA_W:0]   env_up;
  logic [msv_pkg::ENV_W-1:0]       env_next;

  assign env_src   = gate_open ? msv_pkg::ENV_ONE - {1'b0, envelope} : {1'b0, envelope};
  assign env_sum   = {1'b0, env_prod} + msv_pkg::ENV_ROUND;
  assign env_delta = env_sum[msv_pkg::ENV_PROD_W:16];
  assign env_up    = (msv_pkg::ENV_DELTA_W + 1)'(envelope) + {1'b0, env_delta};

  always_comb begin
    if (gate_open) begin
      env_next = (env_up > (msv_pkg::ENV_DELTA_W + 1)'(msv_pkg::ENV_MAX)) ?
                 msv_pkg::ENV_MAX : env_up[msv_pkg::ENV_W-1:0];
    end else begin
      env_next = (env_delta > msv_pkg::ENV_DELTA_W'(envelope)) ?
                 '0 : envelope - env_delta[msv_pkg::ENV_W-1:0];
    end
  end

  // note-on: octave and semitone of key - 69
  logic [msv_pkg::UKEY_W-1:0]      ukey_in;
  logic [msv_pkg::OCT_MUL_W-1:0]   oct_mul;
  logic [msv_pkg::UKEY_W-1:0]      semi_full;
  logic [msv_pkg::STEP_WIDE_W-1:0] step_wide;

  assign ukey_in   = {key[msv_pkg::KEY_W-1], key} + msv_pkg::KEY_BIAS;
  assign oct_mul   = msv_pkg::OCT_MUL_W'(ukey_in) * msv_pkg::RECIP_12;
  assign semi_full = ukey - msv_pkg::UKEY_W'(oct) * msv_pkg::SEMIS;
  assign step_wide = (msv_pkg::STEP_WIDE_W'(note_prod) << msv_pkg::OCT_UP_MAX) >> step_shr;

  // sample formatting
  logic [SB:0]   mix_top;
  logic [SB-1:0] sat;

  assign mix_top = mix[msv_pkg::MIX_W-1:msv_pkg::OUT_SHIFT];
  assign sat     = (mix_top > msv_pkg::SAMPLE_MAX) ? msv_pkg::SAMPLE_MAX[SB-1:0] : mix_top[SB-1:0];

  logic key_neg;
  assign key_neg = key[msv_pkg::KEY_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc  <= '0;
      phase_step <= '0;
      envelope   <= '0;
      gate_open  <= 1'b0;
      held_key   <= msv_pkg::KEY_NONE;
      out_gain   <= msv_pkg::GAIN_RESET;
    end else begin
      if (cmd.note_start) begin
        held_key  <= key;
        gate_open <= 1'b1;
      end
      if (cmd.note_off && (key_neg || (key == held_key))) begin
        gate_open <= 1'b0;
      end
      if (cmd.gain_set) begin
        out_gain <= (gain_value > msv_pkg::GAIN_ONE) ? msv_pkg::GAIN_ONE : gain_value;
      end
      if (cmd.env_update) begin
        envelope <= env_next;
      end
      if (cmd.out_load) begin
        phase_acc <= phase_acc + phase_step;
      end
      if (cmd.note_shift) begin
        phase_step <= step_wide[PB-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick_start) begin
      env_prod <= msv_pkg::ENV_PROD_W'(env_rate) * msv_pkg::ENV_PROD_W'(env_src);
      sine_mag <= rom_word;
    end
    if (cmd.mul1) begin
      mag_env <= msv_pkg::MAG_W'(sine_mag) * msv_pkg::MAG_W'(envelope);
    end
    if (cmd.mul2) begin
      mix <= msv_pkg::MIX_W'(mag_env) * msv_pkg::MIX_W'(out_gain);
    end
    if (cmd.out_load) begin
      sample <= quad[1] ? -sat : sat;
    end
    if (cmd.note_start) begin
      ukey <= ukey_in;
      oct  <= oct_mul[msv_pkg::RECIP_SH +: msv_pkg::OCT_W];
    end
    if (cmd.note_mul) begin
      note_prod <= msv_pkg::NOTE_PROD_W'(a4_increment) *
                   msv_pkg::NOTE_PROD_W'(msv_pkg::semitone_ratio(semi_full[3:0]));
      step_shr  <= msv_pkg::SHIFT_BASE - msv_pkg::SHIFT_W'(oct);
    end
  end

endmodule

// ----- src/mono_sine_voice_with_envelope.sv -----
`timescale 1ns / 1ps
// Top level of the monophonic sine voice with one-pole envelope.
// Depends on msv_pkg, msv_regs, msv_ctrl and msv_dp.
//
// Usage:
//   Input channel (in_valid/in_ready, command, key, gain_value) carries one
//   command per transfer: sample tick, note on, note off/choke or set gain.
//   Only a sample tick produces a result, on the output channel
//   (out_valid/out_ready, sample), a Q1.15 sample.
//   Timing: a tick is taken and then runs envelope update, two multiplies and
//   output formatting through the sequencer states S_ENV, S_MUL1, S_MUL2 and
//   S_OUT; its sample is registered in S_OUT and the next command is taken
//   once the sequencer is back in S_IDLE. Note on steps through the key-to-step
//   multiply and the octave shift; note off and set gain act at their transfer.
//   The output register holds a finished sample while the receiver stalls; note
//   commands still flow, and a following tick waits in its last step until the
//   sample is taken.
//   Reset: synchronous, clears phase, step and envelope, closes the gate, sets
//   gain to 0.8, restores both configuration registers. Configuration is written
//   through the APB-style port only while the voice is idle; left to the user.
module mono_sine_voice_with_envelope (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [1:0]                             command,
  input  logic signed [msv_pkg::KEY_W-1:0]       key,
  input  logic [msv_pkg::GAIN_W-1:0]             gain_value,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [msv_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [msv_pkg::PADDR_W-1:0]            paddr,
  input  logic [msv_pkg::PDATA_W-1:0]            pwdata,
  output logic [msv_pkg::PDATA_W-1:0]            prdata,
  output logic                                   pready
);

  msv_pkg::dp_cmd_t              cmd;
  logic [msv_pkg::RATE_W-1:0]    env_rate;
  logic [msv_pkg::A4_W-1:0]      a4_increment;

  msv_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .env_rate     (env_rate),
    .a4_increment (a4_increment)
  );

  msv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  msv_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .key          (key),
    .gain_value   (gain_value),
    .env_rate     (env_rate),
    .a4_increment (a4_increment),
    .sample       (sample)
  );

endmodule

// ----- tb/sv/tb_mono_sine_voice_with_envelope.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for mono_sine_voice_with_envelope: directed script,
// then randomized command streams per register setting, checked sample by sample.
// Depends on msv_pkg and the voice RTL.
module tb_mono_sine_voice_with_envelope;
  import msv_pkg::*;

  localparam int QUIET       = 12;
  localparam int STALL_LIMIT = 2000;
  localparam int PER_PHASE   = 140;

  typedef enum bit {ROW_XFER, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    cmd_code_t  cmd;
    logic [7:0] key;
    logic [15:0] gain;
    reg_index_t sel;
    logic [31:0] data;
    bit         pinned;
    logic [15:0] pin;
  } script_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] command = CMD_TICK;
  logic signed [KEY_W-1:0] key = '0;
  logic [GAIN_W-1:0] gain_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  mono_sine_voice_with_envelope dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .key(key), .gain_value(gain_value),
    .out_valid(out_valid), .out_ready(out_ready), .sample(sample),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // voice state as predicted
  logic [15:0] v_rate = 16'd273;
  logic [26:0] v_a4 = 27'd39370534;
  logic [31:0] v_phase = '0;
  logic [31:0] v_step = '0;
  logic [15:0] v_env = '0;
  bit v_gate = 1'b0;
  logic signed [7:0] v_key = -8'sd1;
  logic [15:0] v_gain = 16'd26214;

  logic signed [15:0] pending_samples[$];
  logic signed [15:0] want;
  script_row_t script [33];
  bit calm = 1'b0;
  int errors = 0;
  int n_checked = 0, n_ticks = 0, n_on = 0, n_off = 0, n_gain = 0, n_writes = 0;
  int idle_cycles = 0;

  function automatic logic [63:0] ratio_of(int semi);
    case (semi)
      0: return 64'd65536;
      1: return 64'd69433;
      2: return 64'd73562;
      3: return 64'd77936;
      4: return 64'd82570;
      5: return 64'd87480;
      6: return 64'd92682;
      7: return 64'd98193;
      8: return 64'd104032;
      9: return 64'd110218;
      10: return 64'd116772;
      default: return 64'd123715;
    endcase
  endfunction

  function automatic logic [63:0] sine_poly(logic [63:0] x);
    logic [63:0] sq, t;
    sq = (x * x) >> 16;
    t = 64'd42048 - ((64'd4640 * sq) >> 16);
    t = 64'd102944 - ((t * sq) >> 16);
    return (t * x) >> 16;
  endfunction

  function automatic logic [31:0] note_step(logic signed [7:0] k);
    int d, oct, semi;
    logic [63:0] p;
    d = int'(k) - 69;
    oct = (d >= 0) ? d / 12 : -((-d + 11) / 12);
    semi = d - oct * 12;
    p = 64'(v_a4) * ratio_of(semi);
    if (oct >= 0) return 32'((p << oct) >> 16);
    return 32'(p >> (16 - oct));
  endfunction

  function automatic void step_envelope();
    logic [63:0] d;
    if (v_gate) begin
      d = (64'(v_rate) * (64'd65536 - 64'(v_env)) + 64'd65535) >> 16;
      v_env = (64'(v_env) + d > 64'd65535) ? 16'hFFFF : 16'(64'(v_env) + d);
    end else begin
      d = (64'(v_rate) * 64'(v_env) + 64'd65535) >> 16;
      v_env = (d > 64'(v_env)) ? 16'd0 : 16'(64'(v_env) - d);
    end
  endfunction

  function automatic logic signed [15:0] render_sample();
    logic [9:0] idx;
    logic [63:0] x, m;
    idx = v_phase[31:22];
    x = 64'(idx[7:0]) << 8;
    if (idx[8]) x = 64'd65536 - x;
    m = (sine_poly(x) * 64'(v_env) * 64'(v_gain)) >> 32;
    if (m > 64'd32767) m = 64'd32767;
    if (idx[9]) m = -m;
    return m[15:0];
  endfunction

  function automatic bit apply_command(cmd_code_t c, logic signed [7:0] k, logic [15:0] g,
                                       output logic signed [15:0] s);
    bit has;
    has = 1'b0;
    s = '0;
    case (c)
      CMD_TICK: begin
        step_envelope();
        s = render_sample();
        v_phase = v_phase + v_step;
        has = 1'b1;
      end
      CMD_NOTE_ON: begin
        v_key = k;
        v_gate = 1'b1;
        v_step = note_step(k);
      end
      CMD_NOTE_OFF: begin
        if (k < 0 || k == v_key) v_gate = 1'b0;
      end
      default: v_gain = (g > 16'd32768) ? 16'd32768 : g;
    endcase
    return has;
  endfunction

  task automatic send_command(cmd_code_t c, logic signed [7:0] k, logic [15:0] g,
                              bit pinned, logic signed [15:0] pin);
    logic signed [15:0] s;
    if (!calm && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (!calm && $urandom_range(99) < 24) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    key <= k;
    gain_value <= g;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (apply_command(c, k, g, s)) pending_samples.push_back(pinned ? pin : s);
    case (c)
      CMD_TICK: n_ticks++;
      CMD_NOTE_ON: n_on++;
      CMD_NOTE_OFF: n_off++;
      default: n_gain++;
    endcase
  endtask

  // drain all samples, then let a trailing note command finish
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (QUIET) @(posedge clk);
  endtask

  task automatic write_register(reg_index_t sel, logic [31:0] value);
    settle();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (sel)
      REG_ENV_RATE: v_rate = value[15:0];
      default: v_a4 = value[26:0];
    endcase
    n_writes++;
  endtask

  always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 24);

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        $error("sample: expected none, actual %0d", sample);
        errors++;
      end else begin
        want = pending_samples.pop_front();
        n_checked++;
        if (sample !== want) begin
          $error("sample: expected %0d, actual %0d", want, sample);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", STALL_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    cmd_code_t c;
    logic signed [7:0] k;
    logic [15:0] g;
    logic [31:0] rate_cfg, a4_cfg;
    int r;
    script = '{
      // reset state: gate closed, envelope zero
      '{ROW_XFER,  CMD_TICK,     8'h55, 16'hAAAA, REG_ENV_RATE, 32'd0, 1'b1, 16'h0000},
      '{ROW_WRITE, CMD_TICK,     8'h00, 16'h0000, REG_ENV_RATE, 32'd65535, 1'b0, 16'h0},
      '{ROW_WRITE, CMD_TICK,     8'h00, 16'h0000, REG_A4_INC, 32'd67108864, 1'b0, 16'h0},
      '{ROW_XFER,  CMD_SET_GAIN, 8'h00, 16'd32768, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      // key 117 gives a quarter cycle per tick
      '{ROW_XFER,  CMD_NOTE_ON,  8'd117, 16'h0000, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      '{ROW_XFER,  CMD_TICK,     8'hAA, 16'h5555, REG_ENV_RATE, 32'd0, 1'b1, 16'h0000},
      '{ROW_XFER,  CMD_TICK,     8'h7F, 16'hFFFF, REG_ENV_RATE, 32'd0, 1'b1, 16'h7FFF},
      '{ROW_XFER,  CMD_TICK,     8'h80, 16'h0000, REG_ENV_RATE, 32'd0, 1'b1, 16'h0000},
      '{ROW_XFER,  CMD_TICK,     8'h00, 16'h8000, REG_ENV_RATE, 32'd0, 1'b1, 16'h8001},
      '{ROW_XFER,  CMD_NOTE_OFF, 8'hFF, 16'h0000, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      '{ROW_XFER,  CMD_TICK,     8'h01, 16'h0001, REG_ENV_RATE, 32'd0, 1'b1, 16'h0000},
      '{ROW_WRITE, CMD_TICK,     8'h00, 16'h0000, REG_ENV_RATE, 32'd1, 1'b0, 16'h0},
      '{ROW_WRITE, CMD_TICK,     8'h00, 16'h0000, REG_A4_INC, 32'd134217727, 1'b0, 16'h0},
      '{ROW_XFER,  CMD_NOTE_ON,  8'd127, 16'h0000, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      '{ROW_XFER,  CMD_TICK,     8'h00, 16'h0000, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      '{ROW_XFER,  CMD_TICK,     8'h00, 16'h0000, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      // gain above one saturates
      '{ROW_XFER,  CMD_SET_GAIN, 8'h00, 16'hFFFF, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      '{ROW_XFER,  CMD_TICK,     8'h00, 16'h0000, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      '{ROW_XFER,  CMD_NOTE_ON,  8'h80, 16'h0000, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      '{ROW_XFER,  CMD_TICK,     8'h00, 16'h0000, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      '{ROW_XFER,  CMD_NOTE_OFF, 8'd5,  16'h0000, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      '{ROW_XFER,  CMD_TICK,     8'h00, 16'h0000, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      '{ROW_XFER,  CMD_NOTE_OFF, 8'h80, 16'h0000, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      '{ROW_XFER,  CMD_TICK,     8'h00, 16'h0000, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      // zero rate and zero increment hold envelope and phase
      '{ROW_WRITE, CMD_TICK,     8'h00, 16'h0000, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      '{ROW_WRITE, CMD_TICK,     8'h00, 16'h0000, REG_A4_INC, 32'd0, 1'b0, 16'h0},
      '{ROW_XFER,  CMD_NOTE_ON,  8'd0,  16'h0000, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      '{ROW_XFER,  CMD_TICK,     8'h00, 16'h0000, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      '{ROW_XFER,  CMD_TICK,     8'h00, 16'h0000, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      '{ROW_XFER,  CMD_SET_GAIN, 8'h00, 16'h0000, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      '{ROW_XFER,  CMD_TICK,     8'h00, 16'h0000, REG_ENV_RATE, 32'd0, 1'b1, 16'h0000},
      '{ROW_XFER,  CMD_NOTE_OFF, 8'd0,  16'h0000, REG_ENV_RATE, 32'd0, 1'b0, 16'h0},
      '{ROW_XFER,  CMD_TICK,     8'h00, 16'h0000, REG_ENV_RATE, 32'd0, 1'b0, 16'h0}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) write_register(script[i].sel, script[i].data);
      else send_command(script[i].cmd, script[i].key, script[i].gain,
                        script[i].pinned, script[i].pin);
    end

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          rate_cfg = $urandom_range(65535, 1);
          a4_cfg = $urandom_range(134217727, 1);
        end
        1: begin rate_cfg = 32'd65535; a4_cfg = 32'd134217727; end
        2: begin rate_cfg = 32'd0; a4_cfg = 32'd0; end
        3: begin rate_cfg = 32'd1; a4_cfg = 32'd1; end
        4: begin rate_cfg = 32'd273; a4_cfg = 32'd39370534; end
        default: begin
          rate_cfg = 32'($urandom_range(65535));
          a4_cfg = 32'($urandom_range(134217727));
        end
      endcase
      write_register(REG_ENV_RATE, rate_cfg);
      write_register(REG_A4_INC, a4_cfg);
      calm = (ph == 3);
      for (int n = 0; n < PER_PHASE; n++) begin
        if (ph == 0 && n == PER_PHASE / 2) settle();
        r = $urandom_range(99);
        k = 8'($urandom);
        g = 16'($urandom);
        if (r < 58) begin
          c = CMD_TICK;
        end else if (r < 74) begin
          c = CMD_NOTE_ON;
          if ($urandom_range(6) != 0) k = 8'($urandom_range(127));
        end else if (r < 88) begin
          c = CMD_NOTE_OFF;
          case ($urandom_range(3))
            0, 1: k = v_key;
            2: k = -8'sd1;
            default: ;
          endcase
        end else begin
          c = CMD_SET_GAIN;
          if ($urandom_range(3) != 0) g = 16'($urandom_range(32768));
        end
        send_command(c, k, g, 1'b0, 16'h0);
      end
    end
    calm = 1'b0;
    settle();

    $display("Covered %0d ticks, %0d note on, %0d note off, %0d gain changes, %0d writes;",
             n_ticks, n_on, n_off, n_gain, n_writes);
    $display("%0d samples compared across six register settings plus the directed script.",
             n_checked);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- mono_sine_voice_with_envelope.f -----
src/msv_pkg.sv
src/msv_regs.sv
src/msv_ctrl.sv
src/msv_dp.sv
src/mono_sine_voice_with_envelope.sv
tb/sv/tb_mono_sine_voice_with_envelope.sv
